// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion macros used by the RTL top level.
// No dependencies; take in with `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lkfm_pkg.sv =====
// Package for the line keyword flag matcher: constants, keyword tables, types.
// No dependencies.
`default_nettype none

package lkfm_pkg;

  localparam int LINE_LEN  = 32;
  localparam int POS_W     = $clog2(LINE_LEN);
  localparam int KW_COUNT  = 7;
  localparam int KW_SLOTS  = 16;
  localparam int SLOT_W    = $clog2(KW_SLOTS);
  localparam int KW_LEN_W  = 4;

  localparam logic [7:0]        NEWLINE_BYTE = 8'd10;
  localparam logic [POS_W-1:0]  LAST_POS     = POS_W'(LINE_LEN - 1);
  localparam logic [KW_COUNT-1:0] ALL_KW     = '1;

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd6, 4'd7, 4'd7, 4'd8, 4'd10
  };

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
    '{0: "C", 1: "A", 2: "N", default: 8'h00},
    '{0: "R", 1: "S", 2: "4", 3: "8", 4: "5", default: 8'h00},
    '{0: "P", 1: "C", 2: "_", 3: "C", 4: "O", 5: "M", default: 8'h00},
    '{0: "C", 1: "U", 2: "R", 3: "R", 4: "E", 5: "N", 6: "T", default: 8'h00},
    '{0: "V", 1: "O", 2: "L", 3: "T", 4: "A", 5: "G", 6: "E", default: 8'h00},
    '{0: "O", 1: "V", 2: "E", 3: "R", 4: "F", 5: "L", 6: "O", 7: "W",
      default: 8'h00},
    '{0: "T", 1: "E", 2: "M", 3: "P", 4: "E", 5: "R", 6: "A", 7: "T",
      8: "U", 9: "R", default: 8'h00}
  };

  typedef struct packed {
    logic [POS_W-1:0]    pos;
    logic [KW_COUNT-1:0] alive;
    logic [KW_COUNT-1:0] flags;
  } state_t;

  typedef struct packed {
    logic                done;
    logic [KW_COUNT-1:0] hits;
    logic [KW_COUNT-1:0] flags;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lkfm_core.sv =====
// Per-byte match logic: next line state, hits and sticky flags for one byte.
// Depends on lkfm_pkg.
`default_nettype none

module lkfm_core (
  input  lkfm_pkg::state_t  state_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              clear_flags_i,
  output lkfm_pkg::state_t  state_o,
  output lkfm_pkg::result_t result_o
);

  logic                          is_nl;
  logic [lkfm_pkg::KW_COUNT-1:0] flags_base;
  logic [lkfm_pkg::KW_COUNT-1:0] hits;
  logic [lkfm_pkg::KW_COUNT-1:0] miss;
  logic [lkfm_pkg::SLOT_W-1:0]   slot;

  assign is_nl = (rx_byte_i == lkfm_pkg::NEWLINE_BYTE);
  assign flags_base = clear_flags_i ? '0 : state_i.flags;
  assign slot = state_i.pos[lkfm_pkg::SLOT_W-1:0];

  always_comb begin
    for (int k = 0; k < lkfm_pkg::KW_COUNT; k++) begin
      hits[k] = state_i.alive[k] &&
                (state_i.pos >= lkfm_pkg::POS_W'(lkfm_pkg::KW_LEN[k]));
      miss[k] = (state_i.pos < lkfm_pkg::POS_W'(lkfm_pkg::KW_LEN[k])) &&
                (rx_byte_i != lkfm_pkg::KW_TEXT[k][slot]);
    end
  end

  always_comb begin
    state_o = state_i;
    result_o.done  = 1'b0;
    result_o.hits  = '0;
    if (is_nl) begin
      state_o.pos   = '0;
      state_o.alive = lkfm_pkg::ALL_KW;
      state_o.flags = flags_base | hits;
      result_o.done = 1'b1;
      result_o.hits = hits;
    end else begin
      state_o.flags = flags_base;
      if (state_i.pos == lkfm_pkg::LAST_POS) begin
        state_o.pos   = '0;
        state_o.alive = lkfm_pkg::ALL_KW;
      end else begin
        state_o.pos   = state_i.pos + 1'b1;
        state_o.alive = state_i.alive & ~miss;
      end
    end
    result_o.flags = state_o.flags;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/line_keyword_flag_matcher.sv =====
// Line keyword flag matcher top level: input stage, line state, result stage.
// Depends on lkfm_pkg, lkfm_core and assert_macros.svh.
// Path: each byte is registered in the input stage, then its result in the result stage.
// Throughput: one byte per cycle; input stalls only while a held result blocks it.
// Reset: rst_ni low clears both stage valids, line position and flags, and sets all keywords alive.
`default_nettype none
`include "assert_macros.svh"

module line_keyword_flag_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  logic        s_axis_tuser,  // [0] clear_flags
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [6:0] line_hits, [13:7] test_flags, [15:14] zero
  output logic        m_axis_tlast   // line_done
);

  logic              in_v_q, in_v_d;
  logic              out_v_q, out_v_d;
  logic [7:0]        in_byte_q;
  logic              in_clr_q;
  lkfm_pkg::state_t  state_q, state_d;
  lkfm_pkg::result_t res_q, res_d;
  logic              out_ready;
  logic              fire;

  assign out_ready     = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || out_ready;
  assign fire          = in_v_q && out_ready;

  assign in_v_d  = s_axis_tready ? s_axis_tvalid : in_v_q;
  assign out_v_d = out_ready ? in_v_q : out_v_q;

  lkfm_core u_core (
    .state_i       (state_q),
    .rx_byte_i     (in_byte_q),
    .clear_flags_i (in_clr_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q        <= 1'b0;
      out_v_q       <= 1'b0;
      state_q.pos   <= '0;
      state_q.alive <= lkfm_pkg::ALL_KW;
      state_q.flags <= '0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  // hold payload until the stage advances
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_clr_q  <= s_axis_tuser;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = res_q.done;
  assign m_axis_tdata  = {2'b00, res_q.flags, res_q.hits};

  `ASSERT_IMPLIES(a_hits_need_done, clk_i, rst_ni, out_v_q && (res_q.hits != '0),
    res_q.done, "hits reported without line end")
  `ASSERT_IMPLIES(a_hits_in_flags, clk_i, rst_ni, out_v_q,
    (res_q.hits & ~res_q.flags) == '0, "hit not reflected in sticky flags")
  `ASSERT_NEXT(a_newline_restart, clk_i, rst_ni,
    fire && (in_byte_q == lkfm_pkg::NEWLINE_BYTE),
    (state_q.pos == '0) && (state_q.alive == lkfm_pkg::ALL_KW),
    "line state not restarted after newline")
  `ASSERT_NEXT(a_input_holds, clk_i, rst_ni, in_v_q && !out_ready,
    in_v_q && $stable(in_byte_q) && $stable(in_clr_q), "stalled input stage lost its byte")

endmodule

`default_nettype wire
